### rtl/core/ddb_pkg.sv
`default_nettype none

package ddb_pkg;

   // field widths
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 14;
   localparam int unsigned DAYS_W   = 23;   // full day number and day difference
   localparam int unsigned REQ_W    = 48;
   localparam int unsigned RSP_W    = 184;

   localparam int unsigned DAY_COUNT_W     = 22;
   localparam int unsigned WHOLE_YEARS_W   = 14;
   localparam int unsigned EXTRA_MONTHS_W  = 4;
   localparam int unsigned EXTRA_DAYS_W    = 5;
   localparam int unsigned TOTAL_MONTHS_W  = 17;
   localparam int unsigned TOTAL_WEEKS_W   = 19;
   localparam int unsigned TOTAL_HOURS_W   = 27;
   localparam int unsigned TOTAL_MINUTES_W = 33;
   localparam int unsigned TOTAL_SECONDS_W = 39;

   // calendar and time constants
   localparam int unsigned DAYS_PER_YEAR   = 365;
   localparam int unsigned DAYS_PER_MONTH  = 30;
   localparam int unsigned DAYS_PER_WEEK   = 7;
   localparam int unsigned HOURS_PER_DAY   = 24;
   localparam int unsigned MINUTES_PER_DAY = HOURS_PER_DAY * 60;
   localparam int unsigned SECONDS_PER_DAY = MINUTES_PER_DAY * 60;
   localparam int unsigned MONTH_FEB       = 2;

   // year quads / 25 by reciprocal: exact for every 12-bit quad count
   localparam int unsigned QUAD_W       = YEAR_W - 2;
   localparam int unsigned CENT_MAGIC   = 5243;
   localparam int unsigned CENT_MAGIC_W = 13;
   localparam int unsigned CENT_SHIFT   = 17;
   localparam int unsigned CENT_PROD_W  = QUAD_W + CENT_MAGIC_W;
   localparam int unsigned CENT_W       = CENT_PROD_W - CENT_SHIFT;
   localparam int unsigned LEAPS_W      = 13;
   localparam int unsigned MONTH_OFF_W  = 9;
   localparam int unsigned REM_YEAR_W   = 9;

   // pipeline depth: two day-number stages, difference, three divide, three remainder
   localparam int unsigned STAGES = 9;

   typedef struct packed {
      logic [DAY_COUNT_W-1:0]     day_count;
      logic [WHOLE_YEARS_W-1:0]   whole_years;
      logic [TOTAL_MONTHS_W-1:0]  total_months;
      logic [TOTAL_WEEKS_W-1:0]   total_weeks;
      logic [TOTAL_HOURS_W-1:0]   total_hours;
      logic [TOTAL_MINUTES_W-1:0] total_minutes;
      logic [TOTAL_SECONDS_W-1:0] total_seconds;
   } hold_type;

   function automatic logic [MONTH_OFF_W-1:0] month_start(input logic [MONTH_W-1:0] month);
      logic [MONTH_OFF_W-1:0] offset;
      case (month)
         4'd2:    offset = 9'd31;
         4'd3:    offset = 9'd59;
         4'd4:    offset = 9'd90;
         4'd5:    offset = 9'd120;
         4'd6:    offset = 9'd151;
         4'd7:    offset = 9'd181;
         4'd8:    offset = 9'd212;
         4'd9:    offset = 9'd243;
         4'd10:   offset = 9'd273;
         4'd11:   offset = 9'd304;
         4'd12:   offset = 9'd334;
         default: offset = 9'd0;
      endcase
      return offset;
   endfunction

endpackage

`default_nettype wire

### rtl/core/ddb_day_number.sv
`default_nettype none

module ddb_day_number
   import ddb_pkg::*;
(
   input  logic               clock,
   input  logic [1:0]         stage_en,
   input  logic [DAY_W-1:0]   day,
   input  logic [MONTH_W-1:0] month,
   input  logic [YEAR_W-1:0]  year,
   output logic [DAYS_W-1:0]  day_number
);

   logic [DAYS_W-1:0]      y365_ff, y365_in;
   logic [MONTH_OFF_W:0]   offset_ff, offset_in;
   logic                   after_feb_ff, after_feb_in;
   logic                   year_zero_ff, year_zero_in;
   logic                   year_quad_ff, year_quad_in;
   logic [QUAD_W-1:0]      prev_quads_ff, prev_quads_in;
   logic [CENT_PROD_W-1:0] prev_prod_ff, prev_prod_in;
   logic [CENT_PROD_W-1:0] year_prod_ff, year_prod_in;
   logic [DAYS_W-1:0]      number_ff, number_in;

   logic [YEAR_W-1:0]  prev_year;
   logic [CENT_W-1:0]  prev_cent;
   logic [CENT_W-1:0]  year_cent;
   logic [LEAPS_W-1:0] leaps;
   logic               cent_div;
   logic               leap;

   // first stage: products and month offset
   always_comb begin
      prev_year     = year - YEAR_W'(1);
      prev_quads_in = prev_year[YEAR_W-1:2];
      y365_in       = DAYS_W'(year) * DAYS_W'(DAYS_PER_YEAR);
      offset_in     = (MONTH_OFF_W+1)'(month_start(month)) + (MONTH_OFF_W+1)'(day);
      after_feb_in  = month > MONTH_W'(MONTH_FEB);
      year_zero_in  = year == '0;
      year_quad_in  = year[1:0] == 2'b00;
      prev_prod_in  = CENT_PROD_W'(prev_year[YEAR_W-1:2]) * CENT_PROD_W'(CENT_MAGIC);
      year_prod_in  = CENT_PROD_W'(year[YEAR_W-1:2]) * CENT_PROD_W'(CENT_MAGIC);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         y365_ff       <= y365_in;
         offset_ff     <= offset_in;
         after_feb_ff  <= after_feb_in;
         year_zero_ff  <= year_zero_in;
         year_quad_ff  <= year_quad_in;
         prev_quads_ff <= prev_quads_in;
         prev_prod_ff  <= prev_prod_in;
         year_prod_ff  <= year_prod_in;
      end
   end

   // second stage: leap count, leap test, sum
   always_comb begin
      prev_cent = prev_prod_ff[CENT_PROD_W-1:CENT_SHIFT];
      year_cent = year_prod_ff[CENT_PROD_W-1:CENT_SHIFT];
      if (year_zero_ff) begin
         leaps = '0;
      end else begin
         leaps = LEAPS_W'(1) + LEAPS_W'(prev_quads_ff) - LEAPS_W'(prev_cent)
               + LEAPS_W'(prev_cent[CENT_W-1:2]);
      end
      // a small fractional part of the reciprocal product marks a multiple of 25
      cent_div  = year_prod_ff[CENT_SHIFT-1:0] < CENT_SHIFT'(CENT_MAGIC);
      leap      = year_quad_ff && (!cent_div || year_cent[1:0] == 2'b00);
      number_in = y365_ff + DAYS_W'(leaps) + DAYS_W'(offset_ff)
                + DAYS_W'(leap && after_feb_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         number_ff <= number_in;
      end
   end

   assign day_number = number_ff;

endmodule

`default_nettype wire

### rtl/core/ddb_const_div.sv
`default_nettype none

module ddb_const_div
   import ddb_pkg::*;
#(
   parameter int unsigned Width   = DAYS_W,
   parameter int unsigned Divisor = DAYS_PER_YEAR
) (
   input  logic                         clock,
   input  logic [2:0]                   stage_en,
   input  logic [Width-1:0]             dividend,
   output logic [Width-1:0]             quotient,
   output logic [$clog2(Divisor)-1:0]   remainder
);

   localparam int unsigned Shift  = Width + 1;
   localparam int unsigned ProdW  = Width + Shift;
   localparam int unsigned RemW   = $clog2(Divisor);
   localparam logic [Shift-1:0] Magic = Shift'((64'd1 << Shift) / 64'(Divisor));
   localparam logic [Width-1:0] DivC  = Width'(Divisor);

   logic [ProdW-1:0] prod_ff, prod_in;
   logic [Width-1:0] x0_ff;
   logic [Width-1:0] x1_ff;
   logic [Width-1:0] q1_ff, q1_in;
   logic [Width-1:0] qc_ff, qc_in;
   logic [Width-1:0] quot_ff, quot_in;
   logic [RemW-1:0]  rem_ff, rem_in;
   logic [Width-1:0] diff;

   // the estimate undershoots the true quotient by at most one
   always_comb begin
      prod_in = ProdW'(dividend) * ProdW'(Magic);
      q1_in   = prod_ff[ProdW-1:Shift];
      qc_in   = Width'((2*Width)'(q1_in) * (2*Width)'(DivC));
      diff    = x1_ff - qc_ff;
      if (diff >= DivC) begin
         quot_in = q1_ff + Width'(1);
         rem_in  = RemW'(diff - DivC);
      end else begin
         quot_in = q1_ff;
         rem_in  = RemW'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
         x0_ff   <= dividend;
      end
      if (stage_en[1]) begin
         q1_ff <= q1_in;
         qc_ff <= qc_in;
         x1_ff <= x0_ff;
      end
      if (stage_en[2]) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/date_difference_breakdown_unit.sv
`default_nettype none

// Gregorian date difference: each request carries two dates (day, month, year); the
// response gives the absolute difference in days and its breakdown into whole years,
// extra months and days (365-day years, 30-day months), total months, weeks, hours,
// minutes and seconds. Dates are not checked: a day beyond its month just adds days,
// and month 0 or 13..15 adds no month offset. Fields too narrow for a result keep its
// low bits. The block is a nine-stage pipeline that takes one request every cycle unless
// a stall on the response side backs up to its first stage; each response leaves the
// last stage after its request has passed through all nine. A stall holds only the stages
// that are full, so empty stages keep filling.
module date_difference_breakdown_unit
   import ddb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // day_first[4:0], month_first[8:5], year_first[22:9], day_second[27:23],
   // month_second[31:28], year_second[45:32], zero pad[47:46]
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // day_count[21:0], whole_years[35:22], extra_months[39:36], extra_days[44:40],
   // total_months[61:45], total_weeks[80:62], total_hours[107:81],
   // total_minutes[140:108], total_seconds[179:141], zero pad[183:180]
   output logic [RSP_W-1:0] rsp_tdata
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] stage_en;

   logic [DAYS_W-1:0] number_a, number_b;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [DAYS_W-1:0] days_pipe_ff [3];

   logic [DAYS_W-1:0]        div365_q;
   logic [REM_YEAR_W-1:0]    div365_r;
   logic [DAYS_W-1:0]        div30_q;
   logic [4:0]               div30_r;
   logic [DAYS_W-1:0]        div7_q;
   logic [2:0]               div7_r;
   logic [REM_YEAR_W-1:0]    rem30_q;
   logic [EXTRA_DAYS_W-1:0]  rem30_r;

   hold_type          hold_in;
   hold_type          hold_ff [3];
   logic [TOTAL_SECONDS_W-1:0] wide_days;

   // a stage advances when it is empty or the next one advances
   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   ddb_day_number u_number_first (
      .clock      (clock),
      .stage_en   (stage_en[1:0]),
      .day        (req_tdata[4:0]),
      .month      (req_tdata[8:5]),
      .year       (req_tdata[22:9]),
      .day_number (number_a)
   );

   ddb_day_number u_number_second (
      .clock      (clock),
      .stage_en   (stage_en[1:0]),
      .day        (req_tdata[27:23]),
      .month      (req_tdata[31:28]),
      .year       (req_tdata[45:32]),
      .day_number (number_b)
   );

   assign days_in = (number_a > number_b) ? (number_a - number_b) : (number_b - number_a);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         days_ff <= days_in;
      end
      if (stage_en[3]) begin
         days_pipe_ff[0] <= days_ff;
      end
      if (stage_en[4]) begin
         days_pipe_ff[1] <= days_pipe_ff[0];
      end
      if (stage_en[5]) begin
         days_pipe_ff[2] <= days_pipe_ff[1];
      end
   end

   ddb_const_div #(.Width(DAYS_W), .Divisor(DAYS_PER_YEAR)) u_div_year (
      .clock     (clock),
      .stage_en  (stage_en[5:3]),
      .dividend  (days_ff),
      .quotient  (div365_q),
      .remainder (div365_r)
   );

   ddb_const_div #(.Width(DAYS_W), .Divisor(DAYS_PER_MONTH)) u_div_month (
      .clock     (clock),
      .stage_en  (stage_en[5:3]),
      .dividend  (days_ff),
      .quotient  (div30_q),
      .remainder (div30_r)
   );

   ddb_const_div #(.Width(DAYS_W), .Divisor(DAYS_PER_WEEK)) u_div_week (
      .clock     (clock),
      .stage_en  (stage_en[5:3]),
      .dividend  (days_ff),
      .quotient  (div7_q),
      .remainder (div7_r)
   );

   // split the part-year remainder into 30-day months and days
   ddb_const_div #(.Width(REM_YEAR_W), .Divisor(DAYS_PER_MONTH)) u_div_rem (
      .clock     (clock),
      .stage_en  (stage_en[8:6]),
      .dividend  (div365_r),
      .quotient  (rem30_q),
      .remainder (rem30_r)
   );

   always_comb begin
      wide_days             = TOTAL_SECONDS_W'(days_pipe_ff[2]);
      hold_in.day_count     = days_pipe_ff[2][DAY_COUNT_W-1:0];
      hold_in.whole_years   = div365_q[WHOLE_YEARS_W-1:0];
      hold_in.total_months  = div30_q[TOTAL_MONTHS_W-1:0];
      hold_in.total_weeks   = div7_q[TOTAL_WEEKS_W-1:0];
      hold_in.total_hours   = TOTAL_HOURS_W'(wide_days * TOTAL_SECONDS_W'(HOURS_PER_DAY));
      hold_in.total_minutes = TOTAL_MINUTES_W'(wide_days * TOTAL_SECONDS_W'(MINUTES_PER_DAY));
      hold_in.total_seconds = wide_days * TOTAL_SECONDS_W'(SECONDS_PER_DAY);
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         hold_ff[0] <= hold_in;
      end
      if (stage_en[7]) begin
         hold_ff[1] <= hold_ff[0];
      end
      if (stage_en[8]) begin
         hold_ff[2] <= hold_ff[1];
      end
   end

   assign rsp_tdata = {4'b0000,
                       hold_ff[2].total_seconds,
                       hold_ff[2].total_minutes,
                       hold_ff[2].total_hours,
                       hold_ff[2].total_weeks,
                       hold_ff[2].total_months,
                       rem30_r,
                       rem30_q[EXTRA_MONTHS_W-1:0],
                       hold_ff[2].whole_years,
                       hold_ff[2].day_count};

   // the year divider output matches the day count travelling beside it
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |->
         (DAYS_W'((2*DAYS_W)'(div365_q) * (2*DAYS_W)'(DAYS_PER_YEAR)) + DAYS_W'(div365_r)
             == days_pipe_ff[2]) && (div365_r < REM_YEAR_W'(DAYS_PER_YEAR)))
      else $error("year divider out of step with day count");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |->
         (DAYS_W'((2*DAYS_W)'(div30_q) * (2*DAYS_W)'(DAYS_PER_MONTH)) + DAYS_W'(div30_r)
             == days_pipe_ff[2]) && (div30_r < 5'(DAYS_PER_MONTH)))
      else $error("month divider out of step with day count");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff[5] |->
         (DAYS_W'((2*DAYS_W)'(div7_q) * (2*DAYS_W)'(DAYS_PER_WEEK)) + DAYS_W'(div7_r)
             == days_pipe_ff[2]) && (div7_r < 3'(DAYS_PER_WEEK)))
      else $error("week divider out of step with day count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[44:40] < 5'(DAYS_PER_MONTH)) && (rsp_tdata[39:36] <= 4'd12))
      else $error("extra months or days out of range");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(valid_ff[STAGES-2]))
      else $error("response appeared without a request in the stage before");

endmodule

`default_nettype wire

### bench/date_difference_breakdown_unit_tb.sv
`timescale 1ns / 100ps

module date_difference_breakdown_unit_tb;
   import ddb_pkg::*;

   typedef struct {
      logic [DAY_COUNT_W-1:0]     day_count;
      logic [WHOLE_YEARS_W-1:0]   whole_years;
      logic [EXTRA_MONTHS_W-1:0]  extra_months;
      logic [EXTRA_DAYS_W-1:0]    extra_days;
      logic [TOTAL_MONTHS_W-1:0]  total_months;
      logic [TOTAL_WEEKS_W-1:0]   total_weeks;
      logic [TOTAL_HOURS_W-1:0]   total_hours;
      logic [TOTAL_MINUTES_W-1:0] total_minutes;
      logic [TOTAL_SECONDS_W-1:0] total_seconds;
   } date_gap_type;

   localparam int RANDOM_REQUESTS = 630;
   localparam int HOLD_CYCLES     = 60;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 3 * STAGES;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [REQ_W-1:0] pending_requests[$];
   date_gap_type     expected_gaps[$];

   int error_count   = 0;
   int sent_count    = 0;
   int gap_count     = 0;
   int stall_cycles  = 0;
   bit hold_done     = 1'b0;
   int quiet_cycles  = 0;

   date_difference_breakdown_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned start_of_month(logic [MONTH_W-1:0] month);
      case (month)
         4'd2:    return 31;
         4'd3:    return 59;
         4'd4:    return 90;
         4'd5:    return 120;
         4'd6:    return 151;
         4'd7:    return 181;
         4'd8:    return 212;
         4'd9:    return 243;
         4'd10:   return 273;
         4'd11:   return 304;
         4'd12:   return 334;
         default: return 0;
      endcase
   endfunction

   // absolute day index counted from year zero, which itself counts as leap
   function automatic longint unsigned day_index(logic [DAY_W-1:0] day,
                                                 logic [MONTH_W-1:0] month,
                                                 logic [YEAR_W-1:0] year);
      longint unsigned y;
      longint unsigned leaps;
      longint unsigned idx;
      bit              leap_year;
      y = year;
      leaps = (y == 0) ? 0 : 1 + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400;
      leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      idx = y * 365 + leaps + start_of_month(month) + day;
      if (leap_year && month > MONTH_FEB)
         idx += 1;
      return idx;
   endfunction

   function automatic date_gap_type gap_breakdown(logic [REQ_W-1:0] request);
      longint unsigned first_idx;
      longint unsigned second_idx;
      longint unsigned days;
      longint unsigned year_rem;
      date_gap_type    gap;
      first_idx  = day_index(request[4:0], request[8:5], request[22:9]);
      second_idx = day_index(request[27:23], request[31:28], request[45:32]);
      days = (first_idx > second_idx) ? first_idx - second_idx : second_idx - first_idx;
      year_rem = days % 365;
      gap.day_count     = days[DAY_COUNT_W-1:0];
      gap.whole_years   = WHOLE_YEARS_W'(days / 365);
      gap.extra_months  = EXTRA_MONTHS_W'(year_rem / 30);
      gap.extra_days    = EXTRA_DAYS_W'(year_rem % 30);
      gap.total_months  = TOTAL_MONTHS_W'(days / 30);
      gap.total_weeks   = TOTAL_WEEKS_W'(days / 7);
      gap.total_hours   = TOTAL_HOURS_W'(days * 24);
      gap.total_minutes = TOTAL_MINUTES_W'(days * 24 * 60);
      gap.total_seconds = TOTAL_SECONDS_W'(days * 24 * 60 * 60);
      return gap;
   endfunction

   task automatic queue_dates(int d1, int m1, int y1, int d2, int m2, int y2);
      logic [DAY_W-1:0]   day_a;
      logic [MONTH_W-1:0] month_a;
      logic [YEAR_W-1:0]  year_a;
      logic [DAY_W-1:0]   day_b;
      logic [MONTH_W-1:0] month_b;
      logic [YEAR_W-1:0]  year_b;
      day_a   = DAY_W'(d1);
      month_a = MONTH_W'(m1);
      year_a  = YEAR_W'(y1);
      day_b   = DAY_W'(d2);
      month_b = MONTH_W'(m2);
      year_b  = YEAR_W'(y2);
      pending_requests.push_back({2'b00, year_b, month_b, day_b, year_a, month_a, day_a});
   endtask

   task automatic check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // sender: hold the request until it is taken, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_requests.size() != 0 &&
             ((sent_count >= 300 && sent_count < 420) || $urandom_range(99) >= 9)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_requests.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, one long hold-off, and a stretch with none
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_cycles > 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_tready   <= 1'b0;
      end else if (!hold_done && gap_count >= 100) begin
         hold_done    <= 1'b1;
         stall_cycles <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= (gap_count >= 300 && gap_count < 420) || ($urandom_range(99) >= 9);
      end
   end

   always @(posedge clock) begin
      date_gap_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            gap_count <= gap_count + 1;
            if (expected_gaps.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_gaps.pop_front();
               check_field("day_count",     want.day_count,     rsp_tdata[21:0]);
               check_field("whole_years",   want.whole_years,   rsp_tdata[35:22]);
               check_field("extra_months",  want.extra_months,  rsp_tdata[39:36]);
               check_field("extra_days",    want.extra_days,    rsp_tdata[44:40]);
               check_field("total_months",  want.total_months,  rsp_tdata[61:45]);
               check_field("total_weeks",   want.total_weeks,   rsp_tdata[80:62]);
               check_field("total_hours",   want.total_hours,   rsp_tdata[107:81]);
               check_field("total_minutes", want.total_minutes, rsp_tdata[140:108]);
               check_field("total_seconds", want.total_seconds, rsp_tdata[179:141]);
            end
         end
         if (req_tvalid && req_tready) begin
            sent_count <= sent_count + 1;
            expected_gaps.push_back(gap_breakdown(req_tdata));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int pick;
      int y1;
      // same date, extremes of range and of the field widths
      queue_dates(15, 6, 2024, 15, 6, 2024);
      queue_dates(1, 1, 1, 31, 12, 9999);
      queue_dates(31, 12, 9999, 1, 1, 1);
      queue_dates(0, 0, 0, 31, 15, 16383);
      queue_dates(31, 15, 16383, 0, 0, 0);
      queue_dates(31, 15, 16383, 31, 15, 16383);
      // leap day around ordinary, century and quad-century years
      queue_dates(29, 2, 2000, 1, 3, 2000);
      queue_dates(28, 2, 1900, 1, 3, 1900);
      queue_dates(28, 2, 2004, 1, 3, 2004);
      queue_dates(28, 2, 2001, 1, 3, 2001);
      // year zero counts as leap
      queue_dates(1, 2, 0, 1, 3, 0);
      queue_dates(1, 1, 0, 1, 1, 1);
      // months past December still take the leap day
      queue_dates(1, 13, 2000, 1, 13, 1999);
      queue_dates(5, 14, 2000, 5, 1, 2000);
      queue_dates(5, 0, 2023, 5, 1, 2023);
      // unchecked days: zero and past the end of the month
      queue_dates(0, 3, 2021, 1, 3, 2021);
      queue_dates(31, 4, 2021, 1, 5, 2021);
      // day counts at the year, month and week boundaries
      queue_dates(1, 1, 2023, 31, 12, 2023);
      queue_dates(1, 1, 2023, 1, 1, 2024);
      queue_dates(1, 1, 2023, 30, 1, 2023);
      queue_dates(1, 1, 2023, 31, 1, 2023);
      queue_dates(1, 1, 2023, 7, 1, 2023);
      queue_dates(1, 1, 2023, 8, 1, 2023);
      queue_dates(1, 1, 2024, 31, 12, 2024);
      repeat (RANDOM_REQUESTS) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            queue_dates($urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1),
                        $urandom_range(31, 1), $urandom_range(12, 1), $urandom_range(9999, 1));
         end else if (pick < 70) begin
            y1 = $urandom_range(9999, 1);
            queue_dates($urandom_range(31, 1), $urandom_range(12, 1), y1,
                        $urandom_range(31, 1), $urandom_range(12, 1), y1 + $urandom_range(2));
         end else begin
            queue_dates($urandom_range(31), $urandom_range(15), $urandom_range(16383),
                        $urandom_range(31), $urandom_range(15), $urandom_range(16383));
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      while (expected_gaps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/core/ddb_pkg.sv
rtl/core/ddb_day_number.sv
rtl/core/ddb_const_div.sv
rtl/core/date_difference_breakdown_unit.sv
bench/date_difference_breakdown_unit_tb.sv
